>>> src/pdc_pkg.sv
// Shared types and codes for the Playfair digraph cipher block.
package pdc_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_SAME    = 2'd2;

    localparam int NCHAR = 256;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic       is_pair;
        logic [7:0] index;   // load: cell index
        logic [7:0] char_a;  // load: cell character, pair: first character
        logic [7:0] char_b;  // pair: second character
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> src/pdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/pdc_front.sv
// Input side: accepts items, drops loads outside the grid, packs ops for the queue.
module pdc_front #(
    parameter int CELLS = 160
) (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            cmd,
    input  logic [7:0]      cell_index,
    input  logic [7:0]      cell_char,
    input  logic [7:0]      first_char,
    input  logic [7:0]      second_char,
    input  pdc_pkg::q_stat_t q_stat,
    output logic            q_push,
    output pdc_pkg::op_t    q_op
);
    import pdc_pkg::*;

    logic in_range;
    logic accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign in_range = {1'b0, cell_index} < 9'(CELLS);

    always_comb
    begin
        q_op.is_pair = (cmd == CMD_PAIR);
        q_op.index   = cell_index;
        q_op.char_a  = (cmd == CMD_PAIR) ? first_char : cell_char;
        q_op.char_b  = second_char;
    end

    // loads outside the grid are taken and dropped here
    assign q_push = accept && ((cmd == CMD_PAIR) || in_range);

endmodule

>>> src/pdc_queue.sv
// Two-entry op queue between front and back.
module pdc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pdc_pkg::op_t     push_op,
    input  logic             pop,
    output pdc_pkg::op_t     head,
    output pdc_pkg::q_stat_t stat
);
    import pdc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTRW  = $clog2(DEPTH);

    op_t             mem_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTRW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

>>> src/pdc_back.sv
// Execution side: grid and reverse position map, lookup, fallback scan, translation.
module pdc_back #(
    parameter int ROWS = 10,
    parameter int COLS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             direction,
    input  pdc_pkg::q_stat_t q_stat,
    input  pdc_pkg::op_t     q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_first,
    output logic [7:0]       out_second,
    output logic [1:0]       status
);
    import pdc_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int CW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLS);
    localparam int PW    = RW + CLW;

    typedef enum logic [3:0] {
        S_IDLE, S_LD, S_P1, S_P2, S_P3, S_SCAN, S_SCAN_LAST,
        S_WB1, S_WB2, S_RES1, S_RES2, S_RES3, S_DONE
    } state_t;

    // position {row, col}: compares in the same order as the cell index
    function automatic logic [CW-1:0] cell_addr(input logic [PW-1:0] p);
        cell_addr = CW'(p[PW-1:CLW]) * CW'(COLS) + CW'(p[CLW-1:0]);
    endfunction

    function automatic logic [PW-1:0] idx_pos(input logic [CW-1:0] idx);
        logic [RW-1:0] r;
        logic [CW-1:0] base;
        r    = '0;
        base = '0;
        for (int i = 1; i < ROWS; i++)
        begin
            if (idx >= CW'(i * COLS))
            begin
                r    = RW'(i);
                base = CW'(i * COLS);
            end
        end
        idx_pos = {r, CLW'(idx - base)};
    endfunction

    function automatic logic [CLW-1:0] step_col(input logic [CLW-1:0] c, input logic bk);
        if (bk)
            step_col = (c == '0) ? CLW'(COLS - 1) : c - 1'b1;
        else
            step_col = (c == CLW'(COLS - 1)) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [RW-1:0] step_row(input logic [RW-1:0] r, input logic bk);
        if (bk)
            step_row = (r == '0) ? RW'(ROWS - 1) : r - 1'b1;
        else
            step_row = (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    state_t           state_reg;
    op_t              op_reg;
    logic [PW-1:0]    pos1_reg;
    logic [PW-1:0]    pos2_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             hit1_reg;
    logic             f1_reg;
    logic             f2_reg;
    logic [PW-1:0]    scan_cur_reg;
    logic [PW-1:0]    scan_d_reg;
    logic             scan_pend_reg;
    logic [CW-1:0]    b_addr_reg;
    logic [7:0]       res_first_reg;
    logic [7:0]       res_second_reg;
    logic [1:0]       res_status_reg;
    logic             out_valid_reg;
    logic [7:0]       out_first_reg;
    logic [7:0]       out_second_reg;
    logic [1:0]       out_status_reg;
    logic [NCHAR-1:0] valid_reg;

    logic          grid_we;
    logic [CW-1:0] grid_raddr;
    logic [7:0]    grid_rdata;
    logic          map_we;
    logic [7:0]    map_waddr;
    logic [PW-1:0] map_wdata;
    logic [7:0]    map_raddr;
    logic [PW-1:0] map_rdata;
    logic [7:0]    val_idx;
    logic          val_bit;
    logic          val_we;
    logic          val_wdata;
    logic [PW-1:0] ld_pos;
    logic          hit2;
    logic          scan_last;
    logic          out_free;
    logic [CW-1:0] res_a;
    logic [CW-1:0] res_b;
    logic [1:0]    res_st;

    logic [RW-1:0]  r1, r2;
    logic [CLW-1:0] c1, c2;

    assign ld_pos    = idx_pos(op_reg.index[CW-1:0]);
    assign hit2      = (grid_rdata == op_reg.char_b);
    assign scan_last = (scan_cur_reg[PW-1:CLW] == RW'(ROWS - 1))
                    && (scan_cur_reg[CLW-1:0] == CLW'(COLS - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && !q_stat.empty;

    assign val_idx = (state_reg == S_P2 || state_reg == S_WB2) ? op_reg.char_b : op_reg.char_a;
    assign val_bit = valid_reg[val_idx];

    // translation of the two found positions
    always_comb
    begin
        r1 = pos1_reg[PW-1:CLW];
        c1 = pos1_reg[CLW-1:0];
        r2 = pos2_reg[PW-1:CLW];
        c2 = pos2_reg[CLW-1:0];
        res_st = ST_OK;
        priority if (r1 == r2)
        begin
            if (c1 == c2)
            begin
                res_st = ST_SAME;
            end
            res_a = cell_addr({r1, step_col(c1, direction == DIR_DEC)});
            res_b = cell_addr({r2, step_col(c2, direction == DIR_DEC)});
        end
        else if (c1 == c2)
        begin
            res_a = cell_addr({step_row(r1, direction == DIR_DEC), c1});
            res_b = cell_addr({step_row(r2, direction == DIR_DEC), c2});
        end
        else
        begin
            res_a = cell_addr({r1, c2});
            res_b = cell_addr({r2, c1});
        end
    end

    always_comb
    begin
        map_raddr  = op_reg.char_a;
        grid_raddr = cell_addr(scan_cur_reg);
        grid_we    = 1'b0;
        map_we     = 1'b0;
        map_waddr  = op_reg.char_a;
        map_wdata  = ld_pos;
        val_we     = 1'b0;
        val_wdata  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                map_raddr = q_head.char_a;
            end
            S_LD:
            begin
                grid_we = 1'b1;
                // a higher cell wins; a stale entry is caught later by verification
                map_we  = !val_bit || (ld_pos >= map_rdata);
                val_we  = 1'b1;
            end
            S_P1:
            begin
                map_raddr  = op_reg.char_b;
                grid_raddr = cell_addr(map_rdata);
            end
            S_P2:
            begin
                grid_raddr = cell_addr(map_rdata);
            end
            S_WB1:
            begin
                map_we    = f1_reg;
                map_wdata = pos1_reg;
                val_we    = 1'b1;
                val_wdata = f1_reg;
            end
            S_WB2:
            begin
                map_we    = f2_reg;
                map_waddr = op_reg.char_b;
                map_wdata = pos2_reg;
                val_we    = 1'b1;
                val_wdata = f2_reg;
            end
            S_RES1:
            begin
                grid_raddr = res_a;
            end
            S_RES2:
            begin
                grid_raddr = b_addr_reg;
            end
            default:
            begin
            end
        endcase
    end

    pdc_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (op_reg.index[CW-1:0]),
        .wdata (op_reg.char_a),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    pdc_ram #(.WIDTH(PW), .DEPTH(NCHAR)) u_posmap (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (val_we)
        begin
            valid_reg[val_idx] <= val_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            pos1_reg       <= '0;
            pos2_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            hit1_reg       <= 1'b0;
            f1_reg         <= 1'b0;
            f2_reg         <= 1'b0;
            scan_cur_reg   <= '0;
            scan_d_reg     <= '0;
            scan_pend_reg  <= 1'b0;
            b_addr_reg     <= '0;
            res_first_reg  <= '0;
            res_second_reg <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // in S_DONE the output register is reloaded below instead
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // scan compare for the read issued last cycle; later cells override
            if (scan_pend_reg)
            begin
                if (grid_rdata == op_reg.char_a)
                begin
                    pos1_reg <= scan_d_reg;
                    f1_reg   <= 1'b1;
                end
                if (hit2)
                begin
                    pos2_reg <= scan_d_reg;
                    f2_reg   <= 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        op_reg    <= q_head;
                        state_reg <= q_head.is_pair ? S_P1 : S_LD;
                    end
                end
                S_LD:
                begin
                    state_reg <= S_IDLE;
                end
                S_P1:
                begin
                    pos1_reg  <= map_rdata;
                    v1_reg    <= val_bit;
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    pos2_reg  <= map_rdata;
                    v2_reg    <= val_bit;
                    hit1_reg  <= (grid_rdata == op_reg.char_a);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    priority if (!v1_reg || !v2_reg)
                    begin
                        res_first_reg  <= '0;
                        res_second_reg <= '0;
                        res_status_reg <= ST_MISSING;
                        state_reg      <= S_DONE;
                    end
                    else if (hit1_reg && hit2)
                    begin
                        state_reg <= S_RES1;
                    end
                    else
                    begin
                        // map entry went stale after an overwrite: rescan the grid
                        scan_cur_reg <= '0;
                        f1_reg       <= 1'b0;
                        f2_reg       <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scan_d_reg    <= scan_cur_reg;
                    scan_pend_reg <= 1'b1;
                    if (scan_last)
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    else if (scan_cur_reg[CLW-1:0] == CLW'(COLS - 1))
                    begin
                        scan_cur_reg <= {scan_cur_reg[PW-1:CLW] + 1'b1, CLW'(0)};
                    end
                    else
                    begin
                        scan_cur_reg <= scan_cur_reg + 1'b1;
                    end
                end
                S_SCAN_LAST:
                begin
                    scan_pend_reg <= 1'b0;
                    state_reg     <= S_WB1;
                end
                S_WB1:
                begin
                    state_reg <= S_WB2;
                end
                S_WB2:
                begin
                    if (f1_reg && f2_reg)
                    begin
                        state_reg <= S_RES1;
                    end
                    else
                    begin
                        res_first_reg  <= '0;
                        res_second_reg <= '0;
                        res_status_reg <= ST_MISSING;
                        state_reg      <= S_DONE;
                    end
                end
                S_RES1:
                begin
                    b_addr_reg     <= res_b;
                    res_status_reg <= res_st;
                    state_reg      <= S_RES2;
                end
                S_RES2:
                begin
                    res_first_reg <= grid_rdata;
                    state_reg     <= S_RES3;
                end
                S_RES3:
                begin
                    res_second_reg <= grid_rdata;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_first_reg  <= res_first_reg;
                        out_second_reg <= res_second_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign status     = out_status_reg;

endmodule

>>> src/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: front, op queue, execution back end.
// Load: the back end writes the grid cell and updates the reverse position map.
// Pair: the back end looks up both positions in the position map, verifies them in the grid
// and translates; a stale entry adds a full grid scan through the grid read port.
// Throughput: one item per back-end sequence; the 2-entry queue takes input meanwhile until full.
// Reset: async active low clears control, direction and map valid bits; grid undefined.
module playfair_digraph_cipher #(
    parameter int ROWS = 10,
    parameter int COLS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] cell_index,
    input  logic [7:0] cell_char,
    input  logic [7:0] first_char,
    input  logic [7:0] second_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_first,
    output logic [7:0] out_second,
    output logic [1:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction
);
    import pdc_pkg::*;

    logic    direction_reg;
    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    op_t     q_op;
    op_t     q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= direction;
        end
    end

    pdc_front #(.CELLS(ROWS * COLS)) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .cell_index  (cell_index),
        .cell_char   (cell_char),
        .first_char  (first_char),
        .second_char (second_char),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_op        (q_op)
    );

    pdc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    pdc_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .direction  (direction_reg),
        .q_stat     (q_stat),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_first  (out_first),
        .out_second (out_second),
        .status     (status)
    );

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_stat.empty)
        else $error("queue empty after a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

endmodule
